@@ hdl/filled_circle_point_generator_defines.svh @@
// Assertion macros shared by the circle point generator RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef FILLED_CIRCLE_POINT_GENERATOR_DEFINES_SVH
`define FILLED_CIRCLE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FCPG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define FCPG_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/fcpg_pkg.sv @@
// Package for the circle point generator: widths, request codes, walk state types.
// No dependencies; imported by the interfaces and all modules.
package fcpg_pkg;

	localparam int FIELD_BITS  = 16;
	localparam int RADIUS_IN_BITS = 8;
	localparam int COORD_BITS  = 16;
	localparam int RADIUS_BITS = 8;
	localparam int AB_BITS     = RADIUS_BITS + 1;
	localparam int DEC_BITS    = RADIUS_BITS + 5;
	localparam int SUB_BITS    = 3;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	typedef logic [FIELD_BITS-1:0]      field_t;
	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic [RADIUS_BITS-1:0]     radius_t;
	typedef logic signed [AB_BITS-1:0]  ab_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;
	typedef logic [SUB_BITS-1:0]        sub_t;

	localparam sub_t SUB_PAIR_LAST = sub_t'(1);
	localparam sub_t SUB_SIX_LAST  = sub_t'(5);

	typedef enum logic [2:0] {
		PH_PAIR   = 3'b001,
		PH_SIX    = 3'b010,
		PH_CENTER = 3'b100
	} phase_t;

	typedef struct packed {
		logic    busy;
		phase_t  phase;
		ab_t     a;
		ab_t     b;
		dec_t    dec;
		radius_t cnt;
		sub_t    sub;
	} walk_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} pt_t;

	typedef struct packed {
		pt_t    pt;
		field_t color;
	} res_t;

	localparam walk_t WALK_RESET = '{
		busy: 1'b0, phase: PH_PAIR, a: '0, b: '0, dec: '0, cnt: '0, sub: '0
	};

endpackage

@@ hdl/fcpg_req_if.sv @@
// Request channel: valid/ready handshake with start or step payload.
// Depends on fcpg_pkg.
interface fcpg_req_if
	import fcpg_pkg::*;
();
	logic   valid;
	logic   ready;
	logic   req_type;
	field_t center_x;
	field_t center_y;
	logic [RADIUS_IN_BITS-1:0] radius_in;
	field_t pixel_color;

	modport source (output valid, req_type, center_x, center_y, radius_in, pixel_color,
		input ready);
	modport sink (input valid, req_type, center_x, center_y, radius_in, pixel_color,
		output ready);
endinterface

@@ hdl/fcpg_pt_if.sv @@
// Point channel: valid/ready handshake carrying one pixel per transfer.
// Depends on fcpg_pkg.
interface fcpg_pt_if
	import fcpg_pkg::*;
();
	logic   valid;
	logic   ready;
	field_t point_x;
	field_t point_y;
	field_t dot_color;
	logic   last_point;

	modport source (output valid, point_x, point_y, dot_color, last_point, input ready);
	modport sink (input valid, point_x, point_y, dot_color, last_point, output ready);
endinterface

@@ hdl/fcpg_walk.sv @@
// Next-state and point logic of the midpoint circle walk, purely combinational.
// Depends on fcpg_pkg.
module fcpg_walk
	import fcpg_pkg::*;
(
	input  logic    start,
	input  radius_t radius,
	input  coord_t  x0,
	input  coord_t  y0,
	input  walk_t   cur,
	output walk_t   nxt,
	output pt_t     point
);

	localparam dec_t DEC_INIT    = dec_t'(3);
	localparam dec_t DEC_NEG_ADD = dec_t'(6);
	localparam dec_t DEC_POS_ADD = dec_t'(10);

	// Finish one row: advance a, update the decision term, pick the next group.
	function automatic walk_t close_row(walk_t w);
		walk_t r;
		ab_t   a_n;
		ab_t   b_n;
		r   = w;
		a_n = w.a + ab_t'(1);
		b_n = w.b;
		if (w.dec[DEC_BITS-1]) begin
			r.dec = w.dec + (dec_t'(a_n) <<< 2) + DEC_NEG_ADD;
		end else begin
			r.dec = w.dec + DEC_POS_ADD + ((dec_t'(a_n) - dec_t'(w.b)) <<< 2);
			b_n   = w.b - ab_t'(1);
		end
		r.a   = a_n;
		r.b   = b_n;
		r.sub = '0;
		if (a_n <= b_n) begin
			r.phase = PH_PAIR;
			r.cnt   = a_n[RADIUS_BITS-1:0];
		end else begin
			r.phase = PH_CENTER;
			r.cnt   = '0;
		end
		return r;
	endfunction

	walk_t  w_start;
	coord_t off_a;
	coord_t off_b;
	coord_t off_n;

	assign off_a = coord_t'(cur.a[RADIUS_BITS-1:0]);
	assign off_b = coord_t'(cur.b[RADIUS_BITS-1:0]);
	assign off_n = coord_t'(cur.cnt);

	always_comb begin
		w_start       = WALK_RESET;
		w_start.busy  = 1'b1;
		w_start.phase = PH_SIX;
		w_start.b     = ab_t'({1'b0, radius});
		w_start.dec   = DEC_INIT - dec_t'({1'b0, radius, 1'b0});
		w_start.cnt   = radius;
		if (radius == '0) begin
			w_start = close_row(w_start);
		end
	end

	always_comb begin
		nxt        = cur;
		point.x    = x0;
		point.y    = y0;
		point.last = 1'b0;
		if (start) begin
			nxt = w_start;
		end else begin
			unique case (cur.phase)
				PH_PAIR: begin
					if (cur.sub == '0) begin
						point.x = x0 + off_b;
						point.y = y0 - off_n;
					end else begin
						point.x = x0 - off_n;
						point.y = y0 + off_b;
					end
					if (cur.sub == SUB_PAIR_LAST) begin
						nxt.sub = '0;
						if (cur.cnt == radius_t'(1)) begin
							nxt.phase = PH_SIX;
							nxt.cnt   = cur.b[RADIUS_BITS-1:0];
						end else begin
							nxt.cnt = cur.cnt - radius_t'(1);
						end
					end else begin
						nxt.sub = cur.sub + sub_t'(1);
					end
				end
				PH_SIX: begin
					case (cur.sub)
						sub_t'(0): begin point.x = x0 - off_a; point.y = y0 - off_n; end
						sub_t'(1): begin point.x = x0 - off_n; point.y = y0 - off_a; end
						sub_t'(2): begin point.x = x0 + off_a; point.y = y0 - off_n; end
						sub_t'(3): begin point.x = x0 - off_n; point.y = y0 + off_a; end
						sub_t'(4): begin point.x = x0 + off_a; point.y = y0 + off_n; end
						default:   begin point.x = x0 + off_n; point.y = y0 + off_a; end
					endcase
					if (cur.sub == SUB_SIX_LAST) begin
						nxt.sub = '0;
						if (cur.cnt == radius_t'(1)) begin
							nxt = close_row(cur);
						end else begin
							nxt.cnt = cur.cnt - radius_t'(1);
						end
					end else begin
						nxt.sub = cur.sub + sub_t'(1);
					end
				end
				PH_CENTER: begin
					point.last = 1'b1;
					nxt.busy   = 1'b0;
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

endmodule

@@ hdl/filled_circle_point_generator.sv @@
// Filled circle point generator: midpoint walk, one pixel per step request.
// An accepted step registers its point in the output slot, or in the skid slot when the
// output slot holds a point pix does not take. Throughput: one request per cycle
// while pix takes a point every cycle; the walk update and the point come from one
// pass of add/compare logic. A start transfer or a step while idle yields no point.
// Reset (arst_n low) clears the walk state and both output slots; the block comes out idle.
`include "filled_circle_point_generator_defines.svh"
module filled_circle_point_generator
	import fcpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	fcpg_req_if.sink   req,
	fcpg_pt_if.source  pix
);

	// Walk state and values latched at start.
	walk_t  st_q;
	coord_t x0_q;
	coord_t y0_q;
	field_t color_q;

	// Output register plus one skid slot, so one more request is still taken
	// in a cycle where the downstream side stalls.
	logic   out_v_q;
	logic   skid_v_q;
	res_t   out_q;
	res_t   skid_q;

	logic   accept;
	logic   is_start;
	logic   produce;
	logic   out_fire;
	logic   load_from_skid;
	logic   load_new;
	logic   load_skid;
	walk_t  st_nxt;
	pt_t    pt_new;
	res_t   res_new;

	fcpg_walk u_walk (
		.start  (is_start),
		.radius (req.radius_in[RADIUS_BITS-1:0]),
		.x0     (x0_q),
		.y0     (y0_q),
		.cur    (st_q),
		.nxt    (st_nxt),
		.point  (pt_new)
	);

	// Take a request whenever the skid slot is free.
	assign req.ready = !skid_v_q;
	assign accept    = req.valid && req.ready;
	assign is_start  = (req.req_type == REQ_START);
	// Only a step while a circle is in progress emits a point.
	assign produce   = accept && (req.req_type == REQ_STEP) && st_q.busy;

	assign res_new.pt    = pt_new;
	assign res_new.color = color_q;

	assign out_fire       = out_v_q && pix.ready;
	assign load_from_skid = skid_v_q && out_fire;
	assign load_new       = produce && (!out_v_q || out_fire);
	assign load_skid      = produce && out_v_q && !out_fire;

	// Walk state: restart on any start transfer, advance on every emitted point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= WALK_RESET;
		end else if ((accept && is_start) || produce) begin
			st_q <= st_nxt;
		end
	end

	// Hold center and color from the start transfer.
	always_ff @(posedge clk) begin
		if (accept && is_start) begin
			x0_q    <= coord_t'(req.center_x[COORD_BITS-1:0]);
			y0_q    <= coord_t'(req.center_y[COORD_BITS-1:0]);
			color_q <= req.pixel_color;
		end
	end

	// Output slot control: drain skid first, otherwise land the new point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q  <= (out_v_q && !out_fire) || load_from_skid || load_new;
			skid_v_q <= (skid_v_q && !out_fire) || load_skid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_from_skid) begin
			out_q <= skid_q;
		end else if (load_new) begin
			out_q <= res_new;
		end
		if (load_skid) begin
			skid_q <= res_new;
		end
	end

	assign pix.valid      = out_v_q;
	assign pix.point_x    = field_t'(out_q.pt.x);
	assign pix.point_y    = field_t'(out_q.pt.y);
	assign pix.dot_color  = out_q.color;
	assign pix.last_point = out_q.pt.last;

	`FCPG_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q, "skid slot full while output empty")
	`FCPG_ASSERT_IMP(a_group_nonempty, st_q.busy && (st_q.phase != PH_CENTER), st_q.cnt != '0,
		"walk parked on an empty group")
	`FCPG_ASSERT_NXT(a_start_arms, accept && is_start, st_q.busy, "start did not arm the walk")

endmodule
